### rtl/core/lr_pkg.sv
// Shared constants and controller/datapath interface types for the line rasterizer.
package lr_pkg;

   localparam int COORD_BITS_DEF = 6;
   localparam int CODE_BITS      = 8;

   typedef struct packed {
      logic load;   // capture a new request
      logic step;   // advance one pixel
   } cmd_type;

   typedef struct packed {
      logic done;   // current pixel is the end point (or the cut)
   } status_type;

endpackage

### rtl/core/lr_ctrl.sv
// Control state machine of the line rasterizer.
module lr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  lr_pkg::status_type status,
   output lr_pkg::cmd_type    cmd,
   output logic               busy,
   output logic               emit
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (status.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign emit = (state_ff == ST_RUN);

endmodule

### rtl/core/lr_dp.sv
// Datapath of the line rasterizer: position, spans, directions and error term.
module lr_dp #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lr_pkg::cmd_type              cmd,
   input  logic [COORD_BITS-1:0]        x_start,
   input  logic [COORD_BITS-1:0]        y_start,
   input  logic [COORD_BITS-1:0]        x_end,
   input  logic [COORD_BITS-1:0]        y_end,
   input  logic [lr_pkg::CODE_BITS-1:0] code,
   output lr_pkg::status_type           status,
   output logic [COORD_BITS-1:0]        pixel_x,
   output logic [COORD_BITS-1:0]        pixel_y,
   output logic [lr_pkg::CODE_BITS-1:0] paint_code
);

   localparam int ERR_BITS = COORD_BITS + 2;

   logic [COORD_BITS-1:0]        cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]        tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [COORD_BITS-1:0]        span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic                         neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic signed [ERR_BITS-1:0]   err_ff, err_in;
   logic [lr_pkg::CODE_BITS-1:0] code_ff, code_in;
   logic [COORD_BITS-1:0]        count_ff, count_in;

   logic signed [ERR_BITS:0]     err2;
   logic signed [ERR_BITS:0]     neg_span_y;
   logic signed [ERR_BITS-1:0]   sx_ext, sy_ext;
   logic                         move_x, move_y, at_end, cut;
   logic [COORD_BITS-1:0]        dx, dy;

   assign at_end = (cur_x_ff == tgt_x_ff) && (cur_y_ff == tgt_y_ff);
   assign cut    = (count_ff == {COORD_BITS{1'b1}});
   assign status.done = at_end || cut;

   assign sx_ext     = $signed({2'b00, span_x_ff});
   assign sy_ext     = $signed({2'b00, span_y_ff});
   assign err2       = $signed({err_ff, 1'b0});
   assign neg_span_y = -$signed({3'b000, span_y_ff});
   assign move_x     = (err2 > neg_span_y);
   assign move_y     = (err2 < $signed({3'b000, span_x_ff}));

   // absolute differences of the request
   assign dx = (x_end > x_start) ? (x_end - x_start) : (x_start - x_end);
   assign dy = (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);

   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      tgt_x_in  = tgt_x_ff;
      tgt_y_in  = tgt_y_ff;
      span_x_in = span_x_ff;
      span_y_in = span_y_ff;
      neg_x_in  = neg_x_ff;
      neg_y_in  = neg_y_ff;
      err_in    = err_ff;
      code_in   = code_ff;
      count_in  = count_ff;
      if (cmd.load) begin
         cur_x_in  = x_start;
         cur_y_in  = y_start;
         tgt_x_in  = x_end;
         tgt_y_in  = y_end;
         span_x_in = dx;
         span_y_in = dy;
         neg_x_in  = !(x_start < x_end);
         neg_y_in  = !(y_start < y_end);
         err_in    = $signed({2'b00, dx}) - $signed({2'b00, dy});
         code_in   = code;
         count_in  = '0;
      end else if (cmd.step && !status.done) begin
         err_in = err_ff - (move_x ? sy_ext : '0) + (move_y ? sx_ext : '0);
         if (move_x) begin
            cur_x_in = neg_x_ff ? (cur_x_ff - 1'b1) : (cur_x_ff + 1'b1);
         end
         if (move_y) begin
            cur_y_in = neg_y_ff ? (cur_y_ff - 1'b1) : (cur_y_ff + 1'b1);
         end
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         tgt_x_ff  <= '0;
         tgt_y_ff  <= '0;
         span_x_ff <= '0;
         span_y_ff <= '0;
         neg_x_ff  <= 1'b0;
         neg_y_ff  <= 1'b0;
         err_ff    <= '0;
         code_ff   <= '0;
         count_ff  <= '0;
      end else begin
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         tgt_x_ff  <= tgt_x_in;
         tgt_y_ff  <= tgt_y_in;
         span_x_ff <= span_x_in;
         span_y_ff <= span_y_in;
         neg_x_ff  <= neg_x_in;
         neg_y_ff  <= neg_y_in;
         err_ff    <= err_in;
         code_ff   <= code_in;
         count_ff  <= count_in;
      end
   end

   assign pixel_x    = cur_x_ff;
   assign pixel_y    = cur_y_ff;
   assign paint_code = code_ff;

endmodule

### rtl/core/line_rasterizer.sv
// Top level of the Bresenham line rasterizer.
//
// Usage: present a line request on req_* and raise start. The request beat is
// taken at a rising edge with start high and busy low. From the next cycle on
// the block emits one pixel beat per cycle on rsp_*, marked by rsp_valid,
// from the start point to the end point; the end point carries rsp_last_pixel.
// A single-point line gives one beat. Every beat carries the request's code.
//
// A line has N pixels (N = max(|dx|, |dy|) + 1, at most 2**COORD_BITS), one
// beat each; busy drops in the cycle after the last beat, so a new request
// is taken only once the previous line is done. The rate is set by the
// single error-term update in the datapath, one pixel step per cycle.
//
// The receiver cannot stall: each rsp beat is valid for exactly one cycle.
// Reset (synchronous, active high) returns the controller to idle; a line in
// progress is dropped.
module line_rasterizer #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [COORD_BITS-1:0]        req_x_start,
   input  logic [COORD_BITS-1:0]        req_y_start,
   input  logic [COORD_BITS-1:0]        req_x_end,
   input  logic [COORD_BITS-1:0]        req_y_end,
   input  logic [lr_pkg::CODE_BITS-1:0] req_pixel_code,
   output logic                         rsp_valid,
   output logic [COORD_BITS-1:0]        rsp_pixel_x,
   output logic [COORD_BITS-1:0]        rsp_pixel_y,
   output logic [lr_pkg::CODE_BITS-1:0] rsp_paint_code,
   output logic                         rsp_last_pixel
);

   lr_pkg::cmd_type    cmd;
   lr_pkg::status_type status;
   logic               emit;

   // sequence load and pixel steps
   lr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .emit   (emit)
   );

   // hold the line state and walk the error term
   lr_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .x_start    (req_x_start),
      .y_start    (req_y_start),
      .x_end      (req_x_end),
      .y_end      (req_y_end),
      .code       (req_pixel_code),
      .status     (status),
      .pixel_x    (rsp_pixel_x),
      .pixel_y    (rsp_pixel_y),
      .paint_code (rsp_paint_code)
   );

   // every running cycle emits the current pixel
   assign rsp_valid      = emit;
   assign rsp_last_pixel = emit && status.done;

   // an accepted request yields a pixel beat in the next cycle
   a_start_emits: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && rsp_valid)
      else $error("request taken but no pixel beat followed");

   // the last beat ends the line
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_pixel |=> !busy)
      else $error("block still busy after last pixel");

   // beats of one line come back to back
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_pixel |=> rsp_valid)
      else $error("gap inside a line");

   // the code stays fixed across a line
   a_code_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_pixel |=> rsp_paint_code == $past(rsp_paint_code))
      else $error("paint code changed within a line");

endmodule

### tb/tb.sv
// Self-checking testbench for the Bresenham line rasterizer: random and corner-case lines.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB   = lr_pkg::COORD_BITS_DEF;
   localparam int CDB  = lr_pkg::CODE_BITS;
   localparam int GRID = 1 << CB;
   localparam int MAXC = GRID - 1;

   typedef struct {
      logic [CB-1:0]  xs;
      logic [CB-1:0]  ys;
      logic [CB-1:0]  xe;
      logic [CB-1:0]  ye;
      logic [CDB-1:0] code;
   } line_req_type;

   typedef struct {
      logic [CB-1:0]  x;
      logic [CB-1:0]  y;
      logic [CDB-1:0] code;
      logic           last;
   } pixel_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           start = 1'b0;
   logic           busy;
   logic [CB-1:0]  req_x_start = '0;
   logic [CB-1:0]  req_y_start = '0;
   logic [CB-1:0]  req_x_end = '0;
   logic [CB-1:0]  req_y_end = '0;
   logic [CDB-1:0] req_pixel_code = '0;
   logic           rsp_valid;
   logic [CB-1:0]  rsp_pixel_x;
   logic [CB-1:0]  rsp_pixel_y;
   logic [CDB-1:0] rsp_paint_code;
   logic           rsp_last_pixel;

   // Lines waiting for the driver, the line on the request ports, and the
   // pixels the rasterizer still owes us, oldest first.
   line_req_type line_q[$];
   line_req_type shown_line;
   pixel_type    pixel_q[$];

   int lines_queued = 0;
   int lines_taken  = 0;
   int failures     = 0;
   int idle_pct     = 0;   // chance in percent that the driver sits out a cycle

   int idle_pct_list[5] = '{0, 71, 0, 6, 71};

   line_rasterizer uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_pixel_code (req_pixel_code),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_paint_code (rsp_paint_code),
      .rsp_last_pixel (rsp_last_pixel)
   );

   always #1 clock = ~clock;

   // Walk the line the way the block must: one error term, both axes stepping
   // on their own, end point (or the grid-size cut) flagged as last.
   function automatic void trace_line(input line_req_type r);
      logic [CB-1:0]   cx, cy;
      logic signed [7:0] err;
      int              span_x, span_y, e, e2, count;
      bit              neg_x, neg_y, at_end, cut, done;
      pixel_type       p;
      cx     = r.xs;
      cy     = r.ys;
      span_x = (r.xe > r.xs) ? int'(r.xe) - int'(r.xs) : int'(r.xs) - int'(r.xe);
      span_y = (r.ye > r.ys) ? int'(r.ye) - int'(r.ys) : int'(r.ys) - int'(r.ye);
      // An axis that does not move counts as negative; it never steps anyway.
      neg_x  = !(r.xs < r.xe);
      neg_y  = !(r.ys < r.ye);
      err    = 8'(span_x - span_y);
      count  = 0;
      done   = 1'b0;
      while (!done) begin
         at_end = (cx == r.xe) && (cy == r.ye);
         cut    = (count + 1) >= GRID;
         p.x    = cx;
         p.y    = cy;
         p.code = r.code;
         p.last = at_end || cut;
         pixel_q.push_back(p);
         count++;
         if (at_end || cut) begin
            done = 1'b1;
         end else begin
            e  = int'(err);
            e2 = 2 * e;
            if (e2 > -span_y) begin
               e  = e - span_y;
               cx = neg_x ? cx - 1'b1 : cx + 1'b1;
            end
            if (e2 < span_x) begin
               e  = e + span_x;
               cy = neg_y ? cy - 1'b1 : cy + 1'b1;
            end
            err = 8'(e);
         end
      end
   endfunction

   // Driver: a beat is taken at an edge with start high and busy low. Hold the
   // request while busy; once taken (or while nothing is shown) either sit
   // out a cycle or show the next line.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            trace_line(shown_line);
            lines_taken++;
         end
         if (!start || !busy) begin
            if (line_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               shown_line     = line_q.pop_front();
               req_x_start    <= shown_line.xs;
               req_y_start    <= shown_line.ys;
               req_x_end      <= shown_line.xe;
               req_y_end      <= shown_line.ye;
               req_pixel_code <= shown_line.code;
               start          <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every pixel beat lives for one cycle; match it against the
   // oldest owed pixel, field by field.
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid) begin
         if (pixel_q.size() == 0) begin
            $error("unexpected pixel beat x=%0d y=%0d", rsp_pixel_x, rsp_pixel_y);
            failures++;
         end else begin
            want = pixel_q.pop_front();
            if (rsp_pixel_x !== want.x) begin
               $error("pixel_x expected %0d got %0d", want.x, rsp_pixel_x);
               failures++;
            end
            if (rsp_pixel_y !== want.y) begin
               $error("pixel_y expected %0d got %0d", want.y, rsp_pixel_y);
               failures++;
            end
            if (rsp_paint_code !== want.code) begin
               $error("paint_code expected %0d got %0d", want.code, rsp_paint_code);
               failures++;
            end
            if (rsp_last_pixel !== want.last) begin
               $error("last_pixel expected %0d got %0d", want.last, rsp_last_pixel);
               failures++;
            end
         end
      end
   end

   task automatic add_line(input int xs, input int ys, input int xe, input int ye,
                           input int code);
      line_req_type r;
      r.xs   = CB'(xs);
      r.ys   = CB'(ys);
      r.xe   = CB'(xe);
      r.ye   = CB'(ye);
      r.code = CDB'(code);
      line_q.push_back(r);
      lines_queued++;
   endtask

   // Half full-range random lines; the rest short hops, straight runs, diagonals and
   // single points so every octant and the degenerate shapes keep turning up.
   task automatic add_random_line();
      int xs, ys, xe, ye, d;
      xs = $urandom_range(MAXC);
      ys = $urandom_range(MAXC);
      xe = $urandom_range(MAXC);
      ye = $urandom_range(MAXC);
      case ($urandom_range(9))
         5, 6: begin
            xe = $urandom_range((xs + 5 > MAXC) ? MAXC : xs + 5, (xs < 5) ? 0 : xs - 5);
            ye = $urandom_range((ys + 5 > MAXC) ? MAXC : ys + 5, (ys < 5) ? 0 : ys - 5);
         end
         7: begin
            if ($urandom_range(1)) ye = ys;
            else xe = xs;
         end
         8: begin
            d  = $urandom_range(MAXC);
            xe = ($urandom_range(1)) ? ((xs + d > MAXC) ? MAXC : xs + d)
                                     : ((xs < d) ? 0 : xs - d);
            d  = (xe > xs) ? xe - xs : xs - xe;
            ye = (ys + d <= MAXC) ? ys + d : ys - d;
         end
         9: begin
            xe = xs;
            ye = ys;
         end
         default: ;
      endcase
      add_line(xs, ys, xe, ye, $urandom_range(255));
   endtask

   task automatic drain();
      while (lines_taken != lines_queued || pixel_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed lines: single points at two opposite corners, full-length straight
      // runs both ways, both main diagonals, every octant, and the codes
      // at their extremes and alternating bit patterns.
      idle_pct = 0;
      add_line(0, 0, 0, 0, 0);
      add_line(MAXC, MAXC, MAXC, MAXC, 255);
      add_line(0, 0, MAXC, 0, 8'hAA);
      add_line(MAXC, 5, 0, 5, 8'h55);
      add_line(7, 0, 7, MAXC, 1);
      add_line(7, MAXC, 7, 0, 128);
      add_line(0, 0, MAXC, MAXC, 8'hFF);
      add_line(MAXC, MAXC, 0, 0, 8'h0F);
      add_line(MAXC, 0, 0, MAXC, 8'hF0);
      add_line(0, MAXC, MAXC, 0, 2);
      add_line(10, 10, 30, 17, 3);
      add_line(10, 10, 17, 30, 4);
      add_line(10, 10, 3, 30, 5);
      add_line(10, 10, 0, 17, 6);
      add_line(40, 40, 20, 33, 7);
      add_line(40, 40, 33, 20, 8);
      add_line(40, 40, 47, 20, 9);
      add_line(40, 40, 60, 33, 10);
      add_line(0, 0, MAXC, 1, 11);
      add_line(0, MAXC, 1, 0, 12);
      add_line(20, 20, 21, 21, 13);
      add_line(20, 20, 21, 22, 14);
      drain();

      // Random lines under each idling profile in turn; the receiver cannot
      // stall, so its profiles leave only the sender's gaps.
      foreach (idle_pct_list[i]) begin
         idle_pct = idle_pct_list[i];
         repeat (70) add_random_line();
         drain();
      end

      // Let any stray beat show up before calling the result.
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Hang guard: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
